// ===== rtl/mips_subset_execute_assert.svh =====
// Assertion macros for the execute block
`ifndef MIPS_SUBSET_EXECUTE_ASSERT_SVH
`define MIPS_SUBSET_EXECUTE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define MSE_ASSERT_IMP(label, clk, rstn, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// next-cycle implication
`define MSE_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// ===== rtl/mse_pkg.sv =====
// ---------------------------------------------------------------------------
// mse_pkg: shared types and constants
// Opcodes and the decoded-instruction record passed front to back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package mse_pkg;
  localparam int unsigned MemWordsDefault = 1024;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_OR = 5'd2, OP_AND = 5'd3, OP_SLT = 5'd4,
    OP_SLL = 5'd5, OP_SRL = 5'd6, OP_JR = 5'd7, OP_LW = 5'd8, OP_SW = 5'd9,
    OP_ADDI = 5'd10, OP_ORI = 5'd11, OP_ANDI = 5'd12, OP_SLTI = 5'd13,
    OP_BEQ = 5'd14, OP_BNE = 5'd15, OP_LUI = 5'd16, OP_J = 5'd17, OP_JAL = 5'd18
  } op_e;

  typedef struct packed {
    logic [4:0]  func;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [15:0] imm;
    logic [25:0] jidx;
  } instr_t;
endpackage

// ===== rtl/mse_ram.sv =====
// ---------------------------------------------------------------------------
// mse_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module mse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/mse_front.sv =====
// ---------------------------------------------------------------------------
// mse_front: instruction intake
// Two-entry queue holding accepted instructions for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mips_subset_execute_assert.svh"
module mse_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mse_pkg::instr_t in_i,
  output logic            q_valid_o,
  input  logic            q_pop_i,
  output mse_pkg::instr_t q_o
);
  mse_pkg::instr_t ent_q [2];
  logic rp_q, wp_q;
  logic [1:0] cnt_q, cnt_d;
  logic push;

  assign in_ready_o = cnt_q != 2'd2;
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = cnt_q != 2'd0;
  assign q_o = ent_q[rp_q];
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= 1'b0; wp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) ent_q[wp_q] <= in_i;
  end

  `MSE_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, q_pop_i, q_valid_o)
  `MSE_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, cnt_q == 2'd2, !in_ready_o)
  `MSE_ASSERT_NEXT(a_cnt_up, clk_i, rst_ni, push && !q_pop_i, cnt_q != 2'd0)
endmodule

// ===== rtl/mse_back.sv =====
// ---------------------------------------------------------------------------
// mse_back: execute stage
// Stage A: register read, ALU, branch; issues memory read or write. Stage B: output
// register, picks up load data. Loads are forwarded into the next instruction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mips_subset_execute_assert.svh"
module mse_back #(
  parameter int unsigned MemWords = mse_pkg::MemWordsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  mse_pkg::instr_t q_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     next_pc_o,
  output logic            branch_taken_o,
  output logic            reg_write_o,
  output logic [4:0]      reg_number_o,
  output logic [31:0]     reg_value_o,
  output logic            mem_write_o,
  output logic [9:0]      mem_word_index_o,
  output logic [31:0]     mem_value_o
);
  localparam int unsigned AW = $clog2(MemWords);

  logic [31:0] rf_q [32];
  logic [31:0] pc_q, pc_d;
  logic        ov_q, ld_q;
  logic [31:0] rdata;

  // pending load in output register: its value comes from RAM data
  logic [31:0] wval;
  assign wval = ld_q ? rdata : reg_value_o;

  logic go;
  assign go = q_valid_i && (!ov_q || out_ready_i);
  assign q_pop_o = go;
  assign out_valid_o = ov_q;

  logic [31:0] a, b, seq, simm, sum, npc, val;
  logic [31:0] addr;
  logic        taken, wr, mw, isld;
  logic [4:0]  dst;
  logic [AW-1:0] midx;

  function automatic logic [31:0] rd_reg(input logic [31:0] r, input logic [4:0] i,
      input logic pend, input logic [4:0] pn, input logic [31:0] pv);
    rd_reg = (pend && pn == i) ? pv : r;
  endfunction

  always_comb begin
    a = rd_reg(rf_q[q_i.rs], q_i.rs, ov_q && reg_write_o, reg_number_o, wval);
    b = rd_reg(rf_q[q_i.rt], q_i.rt, ov_q && reg_write_o, reg_number_o, wval);
    seq = pc_q + 32'd4;
    simm = {{16{q_i.imm[15]}}, q_i.imm};
    addr = a + simm;
    midx = addr[AW+1:2];
    sum = 32'd0;
    npc = seq; taken = 1'b0; wr = 1'b0; mw = 1'b0; isld = 1'b0;
    dst = 5'd0; val = 32'd0;
    case (q_i.func)
      mse_pkg::OP_ADD: begin wr = 1'b1; dst = q_i.rd; val = a + b; end
      mse_pkg::OP_SUB: begin wr = 1'b1; dst = q_i.rd; val = a - b; end
      mse_pkg::OP_OR:  begin wr = 1'b1; dst = q_i.rd; val = a | b; end
      mse_pkg::OP_AND: begin wr = 1'b1; dst = q_i.rd; val = a & b; end
      mse_pkg::OP_SLT: begin
        wr = 1'b1; dst = q_i.rd; val = {31'd0, $signed(a) < $signed(b)};
      end
      mse_pkg::OP_SLL: begin wr = 1'b1; dst = q_i.rd; val = b << q_i.sa; end
      mse_pkg::OP_SRL: begin wr = 1'b1; dst = q_i.rd; val = b >> q_i.sa; end
      mse_pkg::OP_JR:  begin npc = a; taken = 1'b1; end
      mse_pkg::OP_LW:  begin wr = 1'b1; dst = q_i.rt; isld = 1'b1; end
      mse_pkg::OP_SW:  begin mw = 1'b1; end
      mse_pkg::OP_ADDI: begin wr = 1'b1; dst = q_i.rt; val = addr; end
      mse_pkg::OP_ORI: begin wr = 1'b1; dst = q_i.rt; val = a | {16'd0, q_i.imm}; end
      mse_pkg::OP_ANDI: begin wr = 1'b1; dst = q_i.rt; val = a & {16'd0, q_i.imm}; end
      mse_pkg::OP_SLTI: begin
        wr = 1'b1; dst = q_i.rt; val = {31'd0, $signed(a) < $signed(simm)};
      end
      mse_pkg::OP_BEQ, mse_pkg::OP_BNE: begin
        sum = seq + {simm[29:0], 2'b00};
        if ((a == b) == (q_i.func == mse_pkg::OP_BEQ)) begin
          npc = sum; taken = 1'b1;
        end
      end
      mse_pkg::OP_LUI: begin wr = 1'b1; dst = q_i.rt; val = {q_i.imm, 16'd0}; end
      mse_pkg::OP_J: begin npc = {seq[31:28], q_i.jidx, 2'b00}; taken = 1'b1; end
      mse_pkg::OP_JAL: begin
        wr = 1'b1; dst = 5'd31; val = seq;
        npc = {seq[31:28], q_i.jidx, 2'b00}; taken = 1'b1;
      end
      default: ;
    endcase
    if (!(wr && dst != 5'd0)) begin
      wr = 1'b0; dst = 5'd0; val = 32'd0; isld = 1'b0;
    end
    pc_d = npc;
  end

  logic [9:0] midx_o;
  assign midx_o = (mw || q_i.func == mse_pkg::OP_LW) ? 10'(midx) : 10'd0;

  mse_ram #(.Width(32), .Depth(MemWords)) u_dmem (
    .clk_i(clk_i), .we_i(go && mw), .waddr_i(midx), .wdata_i(b),
    .re_i(go && isld), .raddr_i(midx), .rdata_o(rdata)
  );

  // pending load retires into the register file as its result leaves,
  // unless the incoming instruction overwrites the same register
  logic ld_ret, new_wr;
  assign ld_ret = ov_q && ld_q && (go || out_ready_i);
  assign new_wr = go && wr && !isld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= 32'd0; ov_q <= 1'b0; ld_q <= 1'b0;
      for (int i = 0; i < 32; i++) rf_q[i] <= 32'd0;
    end else begin
      if (ld_ret && !(new_wr && dst == reg_number_o)) rf_q[reg_number_o] <= rdata;
      if (new_wr) rf_q[dst] <= val;
      if (go) begin
        pc_q <= pc_d;
        ov_q <= 1'b1;
        ld_q <= isld;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
        ld_q <= 1'b0;
      end
    end
  end

  logic [31:0] rv_q;
  always_ff @(posedge clk_i) begin
    if (go) begin
      next_pc_o <= pc_d; branch_taken_o <= taken; reg_write_o <= wr;
      reg_number_o <= dst; rv_q <= val; mem_write_o <= mw;
      mem_word_index_o <= midx_o; mem_value_o <= mw ? b : 32'd0;
    end else if (ov_q && ld_q && out_ready_i) begin
      rv_q <= rdata;
    end
  end
  assign reg_value_o = ld_q ? rdata : rv_q;

  `MSE_ASSERT_IMP(a_ld_has_wr, clk_i, rst_ni, ov_q && ld_q, reg_write_o)
  `MSE_ASSERT_IMP(a_wr_nonzero, clk_i, rst_ni, ov_q && reg_write_o, reg_number_o != 5'd0)
  `MSE_ASSERT_NEXT(a_hold, clk_i, rst_ni, ov_q && !out_ready_i, ov_q)
endmodule

// ===== rtl/mips_subset_execute.sv =====
// ---------------------------------------------------------------------------
// mips_subset_execute: execute unit for a MIPS32 subset
// Intake queue in front, register file / ALU / data memory behind it.
// ---------------------------------------------------------------------------
// channel | dir | handshake             | payload
// in      | in  | in_valid_i/in_ready_o | func..jump_index
// out     | out | out_valid_o/out_ready_i| next_pc..mem_value
// One instruction per cycle if out_ready_i; via queue and output register.
// Loads read the data RAM port and the word is bypassed from its registered
// output into the result and into the next instruction's operands.
// Reset clears PC, register file, queue and output valid; no clearing pass.
// A stalled output holds; the two-entry queue keeps accepting until full.
`timescale 1ns / 1ps
module mips_subset_execute #(
  parameter int unsigned MemWords = mse_pkg::MemWordsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  func_i,
  input  logic [4:0]  rs_index_i,
  input  logic [4:0]  rt_index_i,
  input  logic [4:0]  rd_index_i,
  input  logic [4:0]  shift_amount_i,
  input  logic [15:0] immediate_i,
  input  logic [25:0] jump_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] next_pc_o,
  output logic        branch_taken_o,
  output logic        reg_write_o,
  output logic [4:0]  reg_number_o,
  output logic [31:0] reg_value_o,
  output logic        mem_write_o,
  output logic [9:0]  mem_word_index_o,
  output logic [31:0] mem_value_o
);
  mse_pkg::instr_t ins, qi;
  logic qv, pop;
  assign ins = '{func: func_i, rs: rs_index_i, rt: rt_index_i, rd: rd_index_i,
                 sa: shift_amount_i, imm: immediate_i, jidx: jump_index_i};

  mse_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i(ins),
    .q_valid_o(qv), .q_pop_i(pop), .q_o(qi)
  );
  mse_back #(.MemWords(MemWords)) u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_pop_o(pop), .q_i(qi),
    .out_valid_o, .out_ready_i, .next_pc_o, .branch_taken_o, .reg_write_o,
    .reg_number_o, .reg_value_o, .mem_write_o, .mem_word_index_o, .mem_value_o
  );
endmodule
